### rtl/pce_pkg.sv
// Package for the parameterized CRC engine: field widths, register indexes,
// reset values, the configuration struct and bit-reflection helpers.
// No dependencies.
package pce_pkg;

    localparam int CRC_W  = 32;
    localparam int DATA_W = 8;
    localparam int WID_W  = 6;
    localparam int IDX_W  = 3;

    localparam logic [IDX_W-1:0] REG_WIDTH = 3'd0;
    localparam logic [IDX_W-1:0] REG_POLY  = 3'd1;
    localparam logic [IDX_W-1:0] REG_INIT  = 3'd2;
    localparam logic [IDX_W-1:0] REG_XOR   = 3'd3;
    localparam logic [IDX_W-1:0] REG_RIN   = 3'd4;
    localparam logic [IDX_W-1:0] REG_ROUT  = 3'd5;

    localparam logic [WID_W-1:0] RST_WIDTH = 6'd32;
    localparam logic [CRC_W-1:0] RST_POLY  = 32'h04C1_1DB7;
    localparam logic [CRC_W-1:0] RST_INIT  = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] RST_XOR   = 32'hFFFF_FFFF;
    localparam logic             RST_RIN   = 1'b1;
    localparam logic             RST_ROUT  = 1'b1;

    typedef struct packed {
        logic [WID_W-1:0] width;
        logic [CRC_W-1:0] poly;
        logic [CRC_W-1:0] seed;
        logic [CRC_W-1:0] xor_val;
        logic             refl_in;
        logic             refl_out;
    } cfg_t;

    // widths above 32 behave as 32
    function automatic logic [WID_W-1:0] eff_width(input logic [WID_W-1:0] w);
        return (w > 6'd32) ? 6'd32 : w;
    endfunction

    // w is at most 32
    function automatic logic [CRC_W-1:0] width_mask(input logic [WID_W-1:0] w);
        if (w[5])
            return '1;
        else
            return (32'd1 << w[4:0]) - 32'd1;
    endfunction

    // reverse the low w bits of v, w at most 32; zero width gives zero
    function automatic logic [CRC_W-1:0] flip_w(input logic [CRC_W-1:0] v,
                                                input logic [WID_W-1:0] w);
        logic [CRC_W-1:0] r;
        for (int i = 0; i < CRC_W; i++)
        begin
            r[i] = v[CRC_W-1-i];
        end
        return r >> (6'd32 - w);
    endfunction

endpackage

### rtl/pce_cfg.sv
// Configuration register file for the CRC engine.
// Depends on pce_pkg (register indexes, reset values, cfg_t).
module pce_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [pce_pkg::IDX_W-1:0]   cfg_index,
    input  logic [pce_pkg::CRC_W-1:0]   cfg_data,
    output pce_pkg::cfg_t               cfg
);
    import pce_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width    <= RST_WIDTH;
            cfg_reg.poly     <= RST_POLY;
            cfg_reg.seed     <= RST_INIT;
            cfg_reg.xor_val  <= RST_XOR;
            cfg_reg.refl_in  <= RST_RIN;
            cfg_reg.refl_out <= RST_ROUT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH: cfg_reg.width    <= cfg_data[WID_W-1:0];
                REG_POLY:  cfg_reg.poly     <= cfg_data;
                REG_INIT:  cfg_reg.seed     <= cfg_data;
                REG_XOR:   cfg_reg.xor_val  <= cfg_data;
                REG_RIN:   cfg_reg.refl_in  <= cfg_data[0];
                REG_ROUT:  cfg_reg.refl_out <= cfg_data[0];
                default:   ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/pce_byte_fold.sv
// Folds one byte into the reflected CRC register and forms the final result.
// Depends on pce_pkg (cfg_t, eff_width, width_mask, flip_w).
module pce_byte_fold (
    input  pce_pkg::cfg_t                cfg,
    input  logic [pce_pkg::CRC_W-1:0]    crc_in,
    input  logic [pce_pkg::DATA_W-1:0]   data,
    output logic [pce_pkg::CRC_W-1:0]    crc_out,
    output logic [pce_pkg::CRC_W-1:0]    result
);
    import pce_pkg::*;

    logic [WID_W-1:0]  w;
    logic [CRC_W-1:0]  m;
    logic [CRC_W-1:0]  rpoly;
    logic [DATA_W-1:0] b;
    logic [CRC_W-1:0]  t;
    logic [CRC_W-1:0]  res;

    assign w     = eff_width(cfg.width);
    assign m     = width_mask(w);
    assign rpoly = flip_w(cfg.poly, w);

    always_comb
    begin
        for (int i = 0; i < DATA_W; i++)
        begin
            b[i] = cfg.refl_in ? data[i] : data[DATA_W-1-i];
        end
        t = {{(CRC_W-DATA_W){1'b0}}, crc_in[DATA_W-1:0] ^ b};
        for (int k = 0; k < DATA_W; k++)
        begin
            t = t[0] ? ((t >> 1) ^ rpoly) : (t >> 1);
        end
        crc_out = ((crc_in >> DATA_W) ^ (t & m)) & m;
        res     = (crc_out ^ cfg.xor_val) & m;
        result  = cfg.refl_out ? res : flip_w(res, w);
    end

endmodule

### rtl/parameterized_crc_engine.sv
// Parameterized reflected CRC engine, top level.
// Depends on pce_pkg, pce_cfg and pce_byte_fold.
//
// Input channel (in_valid/in_ready): one message word per handshake, data_byte
// plus last_byte, which closes the message. Output channel (out_valid/out_ready):
// one crc_result per message, masked to the configured width. Configuration
// uses a plain write port (cfg_we, cfg_index, cfg_data); write only while no
// message is in flight.
// Timing: an accepted word lands in the input register and is folded from there
// by eight unrolled shift/XOR steps. For a last word the result and out_valid are
// registered when it leaves the input register. One word per cycle is sustained
// while no last word waits for the output register.
// Stall: a waiting result does not block non-last words. A last word waits in
// the input register until the output register is free or drained in the same
// cycle; in_ready is low only while such a word waits.
// Reset: configuration returns to CRC-32 defaults, both registers empty, and
// the next word starts a new message from the configured start value.
module parameterized_crc_engine (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [pce_pkg::IDX_W-1:0]   cfg_index,
    input  logic [pce_pkg::CRC_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [pce_pkg::DATA_W-1:0]  data_byte,
    input  logic                        last_byte,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [pce_pkg::CRC_W-1:0]   crc_result
);
    import pce_pkg::*;

    cfg_t cfg;

    logic              s1_valid_reg, s1_valid_next;
    logic [DATA_W-1:0] s1_byte_reg;
    logic              s1_last_reg;
    logic              busy_reg, busy_next;
    logic [CRC_W-1:0]  crc_reg, crc_next;
    logic              out_valid_reg, out_valid_next;
    logic [CRC_W-1:0]  out_data_reg;

    logic              s1_adv;
    logic              in_take;
    logic [CRC_W-1:0]  init_masked;
    logic [CRC_W-1:0]  crc_start;
    logic [CRC_W-1:0]  crc_folded;
    logic [CRC_W-1:0]  fold_result;

    pce_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign init_masked = cfg.seed & width_mask(eff_width(cfg.width));
    assign crc_start   = busy_reg ? crc_reg : init_masked;

    pce_byte_fold u_fold (
        .cfg     (cfg),
        .crc_in  (crc_start),
        .data    (s1_byte_reg),
        .crc_out (crc_folded),
        .result  (fold_result)
    );

    assign s1_adv   = s1_valid_reg && (!s1_last_reg || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        busy_next      = busy_reg;
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
            out_valid_next = 1'b0;
        if (s1_adv)
        begin
            s1_valid_next = 1'b0;
            if (s1_last_reg)
            begin
                crc_next       = init_masked;
                busy_next      = 1'b0;
                out_valid_next = 1'b1;
            end
            else
            begin
                crc_next  = crc_folded;
                busy_next = 1'b1;
            end
        end
        if (in_take)
            s1_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            busy_reg      <= 1'b0;
            crc_reg       <= RST_INIT & width_mask(eff_width(RST_WIDTH));
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            busy_reg      <= busy_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
        if (s1_adv && s1_last_reg)
            out_data_reg <= fold_result;
    end

    assign out_valid  = out_valid_reg;
    assign crc_result = out_data_reg;

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && s1_last_reg |=> out_valid_reg && !busy_reg)
        else $error("last word did not produce a result");

    a_mid_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && !s1_last_reg |=> out_valid_reg == $past(out_valid_reg && !out_ready))
        else $error("non-last word changed the result register");

    a_mid_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && !s1_last_reg |=> busy_reg)
        else $error("message not marked in progress");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && s1_last_reg && out_valid_reg && !out_ready)
        else $error("input stalled without a blocked last word");

endmodule
